### sv/rc4_stream_cipher_unit_defines.svh
// Assertion macros shared by the RC4 cipher unit modules.
`ifndef RC4_STREAM_CIPHER_UNIT_DEFINES_SVH
`define RC4_STREAM_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RC4_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rc4 check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RC4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rc4 check failed");

`endif

### sv/rc4_pkg.sv
// Shared types and constants of the RC4 cipher unit.
`timescale 1ns / 1ps
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;

  // Input kind carried on in_tuser
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // Datapath command issued by the controller each cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_KEY_STORE,
    DP_PASS,
    DP_INIT,
    DP_SCH_RD,
    DP_SCH_RDJ,
    DP_SCH_WR_N,
    DP_SCH_WR_J,
    DP_KS_RD_I,
    DP_KS_RD_J,
    DP_KS_WR_I,
    DP_KS_WR_J
  } dp_op_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCH_RD,
    ST_SCH_RDJ,
    ST_SCH_WR_N,
    ST_SCH_WR_J,
    ST_KS_RDJ,
    ST_KS_WR_I,
    ST_KS_WR_J
  } ctrl_state_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic keyed;
    logic n_last;
    logic out_free;
  } dp_status_t;

endpackage

### sv/rc4_ctrl.sv
// Controller state machine of the RC4 cipher unit.
`timescale 1ns / 1ps
`include "rc4_stream_cipher_unit_defines.svh"
module rc4_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_tuser,
  input  logic                in_tlast,
  input  rc4_pkg::dp_status_t status,
  output rc4_pkg::dp_op_t     cmd
);

  rc4_pkg::ctrl_state_t state_r, state_nxt;
  logic                 accept;
  logic                 ks_start;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc4_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == rc4_pkg::ST_IDLE) && status.out_free;
  assign accept    = in_tvalid && in_tready;
  assign ks_start  = accept && (in_tuser == rc4_pkg::OP_DATA) && status.keyed;

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd       = rc4_pkg::DP_NOP;
    unique case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_tuser == rc4_pkg::OP_KEY) begin
            cmd = rc4_pkg::DP_KEY_STORE;
            if (in_tlast) begin
              state_nxt = rc4_pkg::ST_INIT;
            end
          end else if (status.keyed) begin
            cmd       = rc4_pkg::DP_KS_RD_I;
            state_nxt = rc4_pkg::ST_KS_RDJ;
          end else begin
            cmd = rc4_pkg::DP_PASS;
          end
        end
      end
      rc4_pkg::ST_INIT: begin
        cmd = rc4_pkg::DP_INIT;
        if (status.n_last) begin
          state_nxt = rc4_pkg::ST_SCH_RD;
        end
      end
      rc4_pkg::ST_SCH_RD: begin
        cmd       = rc4_pkg::DP_SCH_RD;
        state_nxt = rc4_pkg::ST_SCH_RDJ;
      end
      rc4_pkg::ST_SCH_RDJ: begin
        cmd       = rc4_pkg::DP_SCH_RDJ;
        state_nxt = rc4_pkg::ST_SCH_WR_N;
      end
      rc4_pkg::ST_SCH_WR_N: begin
        cmd       = rc4_pkg::DP_SCH_WR_N;
        state_nxt = rc4_pkg::ST_SCH_WR_J;
      end
      rc4_pkg::ST_SCH_WR_J: begin
        cmd       = rc4_pkg::DP_SCH_WR_J;
        state_nxt = status.n_last ? rc4_pkg::ST_IDLE : rc4_pkg::ST_SCH_RD;
      end
      rc4_pkg::ST_KS_RDJ: begin
        cmd       = rc4_pkg::DP_KS_RD_J;
        state_nxt = rc4_pkg::ST_KS_WR_I;
      end
      rc4_pkg::ST_KS_WR_I: begin
        cmd       = rc4_pkg::DP_KS_WR_I;
        state_nxt = rc4_pkg::ST_KS_WR_J;
      end
      rc4_pkg::ST_KS_WR_J: begin
        cmd       = rc4_pkg::DP_KS_WR_J;
        state_nxt = rc4_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  // A keyed data transaction always enters the keystream sequence
  `RC4_ASSERT_NEXT(a_ks_entry, ks_start, state_r == rc4_pkg::ST_KS_RDJ)

endmodule

### sv/rc4_datapath.sv
// Datapath of the RC4 cipher unit: key store, permutation table, indices, output register.
`timescale 1ns / 1ps
`include "rc4_stream_cipher_unit_defines.svh"
module rc4_datapath #(
  parameter int KEY_MAX_BYTES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rc4_pkg::dp_op_t     cmd,
  output rc4_pkg::dp_status_t status,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  localparam int KCW = $clog2(KEY_MAX_BYTES + 1);
  localparam int KAW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

  // Memories
  logic [7:0] perm_mem [rc4_pkg::PERM_DEPTH];
  logic [7:0] key_mem  [KEY_MAX_BYTES];

  // Control registers
  logic [KCW-1:0] key_cnt_r, key_cnt_nxt;
  logic [KCW-1:0] k_r, k_nxt;
  logic [7:0]     n_r, n_nxt;
  logic [7:0]     i_r, i_nxt;
  logic [7:0]     j_r, j_nxt;
  logic           keyed_r, keyed_nxt;
  logic           out_valid_r, out_valid_nxt;

  // Payload registers
  logic [KCW-1:0] key_len_r;
  logic [7:0]     perm_rd_r;
  logic [7:0]     key_rd_r;
  logic [7:0]     s1_r;
  logic [7:0]     sj_r;
  logic [7:0]     t_r;
  logic [7:0]     byte_r;
  logic           last_r;
  logic [7:0]     out_byte_r;
  logic           out_last_r;

  // Combinational controls
  logic           perm_we;
  logic [7:0]     perm_wa;
  logic [7:0]     perm_wd;
  logic           perm_re;
  logic [7:0]     perm_ra;
  logic           key_we;
  logic           key_store_ok;
  logic [KCW-1:0] key_cnt_inc;
  logic [KCW-1:0] k_inc;
  logic [7:0]     sched_j;
  logic [7:0]     ks_j;
  logic [7:0]     ks_t;
  logic [7:0]     ks_byte;
  logic           out_free;
  logic           out_load;
  logic           sched_done;

  assign out_free     = !out_valid_r || out_tready;
  assign key_store_ok = key_cnt_r < KCW'(KEY_MAX_BYTES);
  assign key_cnt_inc  = key_cnt_r + (key_store_ok ? KCW'(1) : KCW'(0));
  assign k_inc        = k_r + KCW'(1);
  assign sched_j      = j_r + key_rd_r + perm_rd_r;
  assign ks_j         = j_r + perm_rd_r;
  assign ks_t         = s1_r + perm_rd_r;
  // Keystream byte after the swap: S[j] was written last, so it is checked first, then S[i]
  assign ks_byte      = (t_r == j_r) ? s1_r : ((t_r == i_r) ? sj_r : perm_rd_r);
  assign out_load     = (cmd == rc4_pkg::DP_PASS) || (cmd == rc4_pkg::DP_KS_WR_J);
  assign sched_done   = (cmd == rc4_pkg::DP_SCH_WR_J) && status.n_last;

  // Command decode for memories and indices
  always_comb begin
    perm_we       = 1'b0;
    perm_wa       = n_r;
    perm_wd       = n_r;
    perm_re       = 1'b0;
    perm_ra       = n_r;
    key_we        = 1'b0;
    key_cnt_nxt   = key_cnt_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    keyed_nxt     = keyed_r;
    unique case (cmd) inside
      rc4_pkg::DP_NOP, rc4_pkg::DP_PASS: begin
      end
      rc4_pkg::DP_KEY_STORE: begin
        key_we      = key_store_ok;
        key_cnt_nxt = in_last ? '0 : key_cnt_inc;
      end
      rc4_pkg::DP_INIT: begin
        perm_we = 1'b1;
        n_nxt   = n_r + 8'd1;
        j_nxt   = '0;
        k_nxt   = '0;
      end
      rc4_pkg::DP_SCH_RD: begin
        perm_re = 1'b1;
      end
      rc4_pkg::DP_SCH_RDJ: begin
        perm_re = 1'b1;
        perm_ra = sched_j;
        j_nxt   = sched_j;
      end
      rc4_pkg::DP_SCH_WR_N: begin
        perm_we = 1'b1;
        perm_wd = perm_rd_r;
      end
      rc4_pkg::DP_SCH_WR_J: begin
        perm_we = 1'b1;
        perm_wa = j_r;
        perm_wd = s1_r;
        n_nxt   = n_r + 8'd1;
        k_nxt   = (k_inc >= key_len_r) ? '0 : k_inc;
        if (status.n_last) begin
          keyed_nxt = 1'b1;
          i_nxt     = '0;
          j_nxt     = '0;
        end
      end
      rc4_pkg::DP_KS_RD_I: begin
        perm_re = 1'b1;
        perm_ra = i_r + 8'd1;
        i_nxt   = i_r + 8'd1;
      end
      rc4_pkg::DP_KS_RD_J: begin
        perm_re = 1'b1;
        perm_ra = ks_j;
        j_nxt   = ks_j;
      end
      rc4_pkg::DP_KS_WR_I: begin
        perm_we = 1'b1;
        perm_wa = i_r;
        perm_wd = perm_rd_r;
        perm_re = 1'b1;
        perm_ra = ks_t;
      end
      rc4_pkg::DP_KS_WR_J: begin
        perm_we = 1'b1;
        perm_wa = j_r;
        perm_wd = s1_r;
      end
      default: begin
      end
    endcase
  end

  // Output register next value
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Permutation table: one write, one registered read
  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_wa] <= perm_wd;
    end
    if (perm_re) begin
      perm_rd_r <= perm_mem[perm_ra];
    end
  end

  // Key store write
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_cnt_r[KAW-1:0]] <= in_byte;
    end
  end

  // Key store registered read
  always_ff @(posedge clk) begin
    if (cmd == rc4_pkg::DP_SCH_RD) begin
      key_rd_r <= key_mem[k_r[KAW-1:0]];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_cnt_r   <= '0;
      k_r         <= '0;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      keyed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      key_cnt_r   <= key_cnt_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      keyed_r     <= keyed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if ((cmd == rc4_pkg::DP_KEY_STORE) && in_last) begin
      key_len_r <= key_cnt_inc;
    end
    if ((cmd == rc4_pkg::DP_SCH_RDJ) || (cmd == rc4_pkg::DP_KS_RD_J)) begin
      s1_r <= perm_rd_r;
    end
    if (cmd == rc4_pkg::DP_KS_WR_I) begin
      sj_r <= perm_rd_r;
      t_r  <= ks_t;
    end
    if (cmd == rc4_pkg::DP_KS_RD_I) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    if (cmd == rc4_pkg::DP_PASS) begin
      out_byte_r <= in_byte;
      out_last_r <= in_last;
    end else if (cmd == rc4_pkg::DP_KS_WR_J) begin
      out_byte_r <= byte_r ^ ks_byte;
      out_last_r <= last_r;
    end
  end

  assign status.keyed    = keyed_r;
  assign status.n_last   = (n_r == 8'hFF);
  assign status.out_free = out_free;

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;

  // A result is only loaded when the output register can take it
  `RC4_ASSERT_IMP(a_out_no_overwrite, out_load, out_free)
  // The end of the key schedule leaves a keyed table with both indices cleared
  `RC4_ASSERT_NEXT(a_sched_done, sched_done, keyed_r && (i_r == 8'd0) && (j_r == 8'd0))

endmodule

### sv/rc4_stream_cipher_unit.sv
// RC4 stream cipher unit: top level joining controller and datapath.
// Input transactions carry a key byte (in_tuser low) or a data byte (in_tuser high). Key bytes
// are kept up to KEY_MAX_BYTES; later ones are dropped. The key byte with in_tlast set starts
// the key schedule, which holds in_tready low after that transaction while it writes the
// identity permutation and then runs the 256 swap rounds, paced by the single write port of the
// permutation table. A data byte after a key schedule is accepted with the read of S[i], then
// S[j] is read, then the two swap writes follow with the S[i]+S[j] read alongside the first, as
// set by the dependent reads and writes on that table; a data byte before any key is returned
// unchanged. Every data byte gives one output transaction with its in_tlast echoed on out_tlast;
// the next input is taken while a result still waits in the output register, as long as that
// register frees up in the same cycle.
`timescale 1ns / 1ps
module rc4_stream_cipher_unit #(
  parameter int KEY_MAX_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] value_byte
  input  logic       in_tuser,   // [0] op: 0 key byte, 1 data byte
  input  logic       in_tlast,   // is_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // end_of_message
);

  rc4_pkg::dp_op_t     cmd;
  rc4_pkg::dp_status_t status;

  // Sequencing
  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .status    (status),
    .cmd       (cmd)
  );

  // Storage and arithmetic
  rc4_datapath #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule
